// ===== sv/hmt_pkg.sv =====
// ----------------------------------------------------------------------------
// hmt_pkg: shared types for the heartbeat membership table
// entry layout, request and configuration bundles, command and event codes
// ----------------------------------------------------------------------------
package hmt_pkg;

  typedef enum logic [1:0] {
    CMD_JOIN_REQ = 2'd0,
    CMD_JOIN_REP = 2'd1,
    CMD_MERGE    = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    EV_ADDED   = 3'd0,
    EV_RAISED  = 3'd1,
    EV_SAME    = 3'd2,
    EV_FULL    = 3'd3,
    EV_REMOVED = 3'd4,
    EV_PING    = 3'd5
  } ev_e;

  typedef enum logic [2:0] {
    HM_IDLE   = 3'd0,
    HM_FIND   = 3'd1,
    HM_FINISH = 3'd2,
    HM_SWEEP  = 3'd3,
    HM_PING   = 3'd4
  } head_mode_e;

  // register indexes on the configuration port
  localparam logic [1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_OWN_ID   = 2'd1;
  localparam logic [1:0] REG_OWN_PORT = 2'd2;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic [31:0] ls;
  } ent_data_t;

  typedef struct packed {
    logic      valid;
    ent_data_t data;
  } entry_t;

  typedef struct packed {
    logic rotate;
    logic compact;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic [31:0] et;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [15:0] timeout;
    logic [31:0] own_id;
    logic [15:0] own_port;
  } cfg_t;

  typedef struct packed {
    ev_e         ev;
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
  } res_t;

endpackage

// ===== sv/hmt_cell.sv =====
// ----------------------------------------------------------------------------
// hmt_cell: one slot of the membership chain
// holds one entry; rotates it to the next cell, closes gaps, or loads a new one
// ----------------------------------------------------------------------------
module hmt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hmt_pkg::cell_ctrl_t ctrl_i,
  input  hmt_pkg::entry_t    lower_i,
  input  logic               lower_vld_i,
  input  hmt_pkg::entry_t    upper_i,
  input  hmt_pkg::entry_t    load_i,
  output hmt_pkg::entry_t    entry_o
);
  import hmt_pkg::*;

  logic      vld_q, vld_d;
  ent_data_t pay_q, pay_d;

  always_comb begin
    vld_d = vld_q;
    pay_d = pay_q;
    if (ctrl_i.rotate) begin
      vld_d = lower_i.valid;
      pay_d = lower_i.data;
    end else if (ctrl_i.compact) begin
      if (vld_q) begin
        // hop down into an empty neighbour
        if (!lower_vld_i) begin
          vld_d = 1'b0;
        end
      end else if (upper_i.valid) begin
        vld_d = 1'b1;
        pay_d = upper_i.data;
      end
    end else if (ctrl_i.load) begin
      vld_d = load_i.valid;
      pay_d = load_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  assign entry_o.valid = vld_q;
  assign entry_o.data  = pay_q;

endmodule

// ===== sv/hmt_head.sv =====
// ----------------------------------------------------------------------------
// hmt_head: processing point at the top of the chain
// looks at the entry leaving the top cell, updates it and forms the event
// ----------------------------------------------------------------------------
module hmt_head (
  input  hmt_pkg::head_mode_e mode_i,
  input  hmt_pkg::entry_t     tap_i,
  input  hmt_pkg::req_t       req_i,
  input  hmt_pkg::cfg_t       cfg_i,
  input  logic                found_i,
  input  logic                full_i,
  output hmt_pkg::entry_t     entry_o,
  output logic                res_vld_o,
  output hmt_pkg::res_t       res_o,
  output logic                keep_o
);
  import hmt_pkg::*;

  logic        key_hit;
  logic        own_hit;
  logic        raise;
  logic [31:0] age;
  logic        aged;

  assign key_hit = tap_i.valid && (tap_i.data.id == req_i.id) &&
                   (tap_i.data.port == req_i.port);
  assign own_hit = tap_i.valid && (tap_i.data.id == cfg_i.own_id) &&
                   (tap_i.data.port == cfg_i.own_port);
  assign raise   = (req_i.cmd == CMD_MERGE) && (req_i.hb > tap_i.data.hb);
  assign age     = req_i.now - tap_i.data.ls;
  // a refreshed own entry has age zero
  assign aged    = own_hit ? (cfg_i.timeout == 16'd0) : (age >= {16'd0, cfg_i.timeout});

  always_comb begin
    entry_o   = tap_i;
    res_vld_o = 1'b0;
    res_o.ev  = EV_SAME;
    res_o.id  = req_i.id;
    res_o.port = req_i.port;
    res_o.hb  = tap_i.data.hb;
    keep_o    = 1'b0;
    case (mode_i)
      HM_FIND: begin
        if (key_hit) begin
          res_vld_o = 1'b1;
          if (raise) begin
            entry_o.data.hb = req_i.hb;
            entry_o.data.ls = req_i.now;
            res_o.ev = EV_RAISED;
            res_o.hb = req_i.hb;
          end
        end
      end
      HM_FINISH: begin
        entry_o.valid     = 1'b1;
        entry_o.data.id   = req_i.id;
        entry_o.data.port = req_i.port;
        entry_o.data.hb   = req_i.hb;
        entry_o.data.ls   = (req_i.cmd == CMD_JOIN_REQ) ? req_i.now : req_i.et;
        res_vld_o = !found_i;
        res_o.ev  = full_i ? EV_FULL : EV_ADDED;
        res_o.hb  = full_i ? 32'd0 : req_i.hb;
      end
      HM_SWEEP: begin
        if (own_hit) begin
          entry_o.data.hb = tap_i.data.hb + 32'd1;
          entry_o.data.ls = req_i.now;
        end
        res_o.id   = tap_i.data.id;
        res_o.port = tap_i.data.port;
        res_o.hb   = entry_o.data.hb;
        res_o.ev   = EV_REMOVED;
        if (tap_i.valid) begin
          if (aged) begin
            entry_o.valid = 1'b0;
            res_vld_o     = 1'b1;
          end else begin
            keep_o = 1'b1;
          end
        end
      end
      HM_PING: begin
        res_vld_o  = tap_i.valid;
        res_o.ev   = EV_PING;
        res_o.id   = tap_i.data.id;
        res_o.port = tap_i.data.port;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/heartbeat_membership_table_unit.sv =====
// ----------------------------------------------------------------------------
// heartbeat_membership_table_unit: gossip heartbeat membership table
// a ring of DEPTH cells rotates its entries past one processing head
// ----------------------------------------------------------------------------
//  channel  | signals                                   | transfer when
//  ---------+-------------------------------------------+----------------------
//  command  | start, busy, command_i .. current_time_i  | start && !busy
//  result   | out_valid_o, event_res_o .. last_of_run_o | out_valid_o (1 cycle)
//  config   | psel, penable, pwrite, paddr, pwdata, ... | psel&penable&pwrite
//
//  join request, join reply and merge run one full turn of the cell ring to
//  search, then an append step and a flush of the held event.
//  a tick runs a sweep turn, a gap-closing pass over the chain, a ping turn
//  and a flush; events leave one at a time.
//  reset empties the table at once (per-cell valid flops), no clearing pass.
//  the receiver cannot stall: each event is shown for one cycle only.
// ----------------------------------------------------------------------------
module heartbeat_membership_table_unit #(
  parameter int DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [31:0] member_id_i,
  input  logic [15:0] member_port_i,
  input  logic [31:0] heartbeat_value_i,
  input  logic [31:0] entry_time_i,
  input  logic [31:0] current_time_i,
  output logic        out_valid_o,
  output logic [2:0]  event_res_o,
  output logic [31:0] out_id_o,
  output logic [15:0] out_port_o,
  output logic [31:0] out_heartbeat_o,
  output logic        last_of_run_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hmt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(2 * DEPTH);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_FIND    = 7'b0000010,
    ST_FINISH  = 7'b0000100,
    ST_SWEEP   = 7'b0001000,
    ST_COMPACT = 7'b0010000,
    ST_PING    = 7'b0100000,
    ST_FLUSH   = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  logic [SW-1:0] step_q, step_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] surv_q, surv_d;
  logic          found_q, found_d;
  req_t          req_q;
  cfg_t          cfg_q;

  logic          pend_vld_q;
  res_t          pend_q;
  logic          out_valid_q;
  res_t          out_q;
  logic          out_last_q;

  head_mode_e    mode;
  entry_t        head_entry;
  logic          res_vld;
  res_t          res;
  logic          keep;
  logic          full;
  logic          accept;
  logic          cfg_wr;
  logic          rot_en;
  logic          cmp_en;
  logic          ld_en;
  logic          rot_last;
  logic          cmp_last;

  entry_t        cell_q [DEPTH];
  logic [DEPTH-1:0] cell_vld;
  logic [DEPTH-1:0] vld_mask;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign full     = (count_q == CW'(DEPTH));
  assign rot_last = (step_q == SW'(DEPTH - 1));
  assign cmp_last = (step_q == SW'(2 * DEPTH - 1));
  assign rot_en   = (state_q == ST_FIND) || (state_q == ST_SWEEP) || (state_q == ST_PING);
  assign cmp_en   = (state_q == ST_COMPACT);
  assign ld_en    = (state_q == ST_FINISH) && !found_q && !full;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout  <= 16'd20;
      cfg_q.own_id   <= 32'd1;
      cfg_q.own_port <= 16'd0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_TIMEOUT:  cfg_q.timeout  <= pwdata[15:0];
        REG_OWN_ID:   cfg_q.own_id   <= pwdata;
        REG_OWN_PORT: cfg_q.own_port <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TIMEOUT:  prdata = {16'd0, cfg_q.timeout};
      REG_OWN_ID:   prdata = cfg_q.own_id;
      REG_OWN_PORT: prdata = {16'd0, cfg_q.own_port};
      default:      prdata = 32'd0;
    endcase
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.cmd  <= cmd_e'(command_i);
      req_q.id   <= member_id_i;
      req_q.port <= member_port_i;
      req_q.hb   <= heartbeat_value_i;
      req_q.et   <= entry_time_i;
      req_q.now  <= current_time_i;
    end
  end

  // head mode follows the sequencer
  always_comb begin
    case (state_q)
      ST_FIND:   mode = HM_FIND;
      ST_FINISH: mode = HM_FINISH;
      ST_SWEEP:  mode = HM_SWEEP;
      ST_PING:   mode = HM_PING;
      default:   mode = HM_IDLE;
    endcase
  end

  hmt_head u_head (
    .mode_i    (mode),
    .tap_i     (cell_q[DEPTH-1]),
    .req_i     (req_q),
    .cfg_i     (cfg_q),
    .found_i   (found_q),
    .full_i    (full),
    .entry_o   (head_entry),
    .res_vld_o (res_vld),
    .res_o     (res),
    .keep_o    (keep)
  );

  // the ring: cell 0 takes from the head, the top cell feeds the head
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     lower;
    entry_t     upper;
    logic       lower_vld;

    assign ctrl.rotate  = rot_en;
    assign ctrl.compact = cmp_en;
    assign ctrl.load    = ld_en && (count_q == CW'(g));

    if (g == 0) begin : g_first
      assign lower     = head_entry;
      assign lower_vld = 1'b1;
    end else begin : g_rest
      assign lower     = cell_q[g-1];
      assign lower_vld = cell_q[g-1].valid;
    end

    if (g == DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = cell_q[g+1];
    end

    hmt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .lower_i     (lower),
      .lower_vld_i (lower_vld),
      .upper_i     (upper),
      .load_i      (head_entry),
      .entry_o     (cell_q[g])
    );

    assign cell_vld[g] = cell_q[g].valid;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    count_d = count_q;
    surv_d  = surv_q;
    found_d = found_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          step_d  = '0;
          surv_d  = '0;
          found_d = 1'b0;
          state_d = (cmd_e'(command_i) == CMD_TICK) ? ST_SWEEP : ST_FIND;
        end
      end
      ST_FIND: begin
        step_d = step_q + SW'(1);
        if (res_vld) begin
          found_d = 1'b1;
        end
        if (rot_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (ld_en) begin
          count_d = count_q + CW'(1);
        end
        state_d = ST_FLUSH;
      end
      ST_SWEEP: begin
        step_d = step_q + SW'(1);
        if (keep) begin
          surv_d = surv_q + CW'(1);
        end
        if (rot_last) begin
          step_d  = '0;
          state_d = ST_COMPACT;
        end
      end
      ST_COMPACT: begin
        step_d = step_q + SW'(1);
        if (cmp_last) begin
          step_d  = '0;
          count_d = surv_q;
          state_d = ST_PING;
        end
      end
      ST_PING: begin
        step_d = step_q + SW'(1);
        if (rot_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      count_q <= '0;
      surv_q  <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      count_q <= count_d;
      surv_q  <= surv_d;
      found_q <= found_d;
    end
  end

  // one event held back so the final one of a run can be marked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      if (res_vld) begin
        pend_vld_q  <= 1'b1;
        out_valid_q <= pend_vld_q;
      end else if (state_q == ST_FLUSH) begin
        pend_vld_q  <= 1'b0;
        out_valid_q <= pend_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      pend_q     <= res;
      out_q      <= pend_q;
      out_last_q <= 1'b0;
    end else if (state_q == ST_FLUSH) begin
      out_q      <= pend_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = out_q.ev;
  assign out_id_o        = out_q.id;
  assign out_port_o      = out_q.port;
  assign out_heartbeat_o = out_q.hb;
  assign last_of_run_o   = out_last_q;

  always_comb begin
    vld_mask = (DEPTH'(1) << count_q) - DEPTH'(1);
  end

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond table depth");

  a_packed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cell_vld == vld_mask))
    else $error("valid entries not packed at the low cells when idle");

  a_no_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_vld_q)
    else $error("held event left over after a run");

  a_out_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(busy))
    else $error("event shown outside a run");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIND && found_q) |-> !res_vld)
    else $error("member found twice in one search");

endmodule

// ===== tb/hmt_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// hmt_tb_pkg: table predictor and event scoreboard for the membership table
// keeps its own ordered copy of the table and the register values, and turns
// each accepted command into the events the block should emit
// ----------------------------------------------------------------------------
package hmt_tb_pkg;
  import hmt_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    ev_e         ev;
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic        last;
  } table_event_t;

  class membership_scoreboard;
    logic [15:0]  timeout;
    logic [31:0]  own_id;
    logic [15:0]  own_port;
    ent_data_t    members[$];
    table_event_t pending_events[$];
    int unsigned  fails;

    function new();
      timeout  = 16'd20;
      own_id   = 32'd1;
      own_port = 16'd0;
      fails    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_TIMEOUT:  timeout  = val[15:0];
        REG_OWN_ID:   own_id   = val;
        REG_OWN_PORT: own_port = val[15:0];
        default: ;
      endcase
    endfunction

    function int pending_count();
      return pending_events.size();
    endfunction

    function int locate(logic [31:0] id, logic [15:0] port);
      foreach (members[i]) begin
        if (members[i].id == id && members[i].port == port) return i;
      end
      return -1;
    endfunction

    function void expect_event(ev_e ev, logic [31:0] id, logic [15:0] port, logic [31:0] hb);
      table_event_t e;
      e.ev   = ev;
      e.id   = id;
      e.port = port;
      e.hb   = hb;
      e.last = 1'b0;
      pending_events.insert(pending_events.size(), e);
    endfunction

    function void note_command(req_t r);
      int           idx;
      int           prior_size;
      logic [31:0]  age;
      ent_data_t    e;
      ent_data_t    survivors[$];
      prior_size = pending_events.size();
      if (r.cmd != CMD_TICK) begin
        idx = locate(r.id, r.port);
        if (idx < 0) begin
          if (members.size() >= TABLE_DEPTH) begin
            expect_event(EV_FULL, r.id, r.port, 32'd0);
          end else begin
            e.id   = r.id;
            e.port = r.port;
            e.hb   = r.hb;
            e.ls   = (r.cmd == CMD_JOIN_REQ) ? r.now : r.et;
            members.insert(members.size(), e);
            expect_event(EV_ADDED, r.id, r.port, r.hb);
          end
        end else if (r.cmd == CMD_MERGE && r.hb > members[idx].hb) begin
          members[idx].hb = r.hb;
          members[idx].ls = r.now;
          expect_event(EV_RAISED, r.id, r.port, r.hb);
        end else begin
          expect_event(EV_SAME, r.id, r.port, members[idx].hb);
        end
      end else begin
        idx = locate(own_id, own_port);
        if (idx >= 0) begin
          members[idx].hb = members[idx].hb + 32'd1;
          members[idx].ls = r.now;
        end
        // walk from the tail so survivors come out in their original order
        for (int j = members.size() - 1; j >= 0; j--) begin
          age = r.now - members[j].ls;
          if (age >= {16'd0, timeout}) begin
            expect_event(EV_REMOVED, members[j].id, members[j].port, members[j].hb);
          end else begin
            survivors.push_front(members[j]);
          end
        end
        members = survivors;
        for (int j = members.size() - 1; j >= 0; j--) begin
          expect_event(EV_PING, members[j].id, members[j].port, members[j].hb);
        end
      end
      if (pending_events.size() > prior_size) begin
        pending_events[pending_events.size() - 1].last = 1'b1;
      end
    endfunction

    task report(string msg);
      if (fails < 30) $display("mismatch: %s", msg);
      fails++;
    endtask

    task check_event(table_event_t got);
      table_event_t want;
      if (pending_events.size() == 0) begin
        report($sformatf("event %0d id %h port %h with nothing pending",
                         got.ev, got.id, got.port));
        return;
      end
      want = pending_events.pop_front();
      if (got.ev !== want.ev)
        report($sformatf("event got %0d want %0d (id %h)", got.ev, want.ev, want.id));
      if (got.id !== want.id)
        report($sformatf("id got %h want %h", got.id, want.id));
      if (got.port !== want.port)
        report($sformatf("port got %h want %h (id %h)", got.port, want.port, want.id));
      if (got.hb !== want.hb)
        report($sformatf("heartbeat got %h want %h (id %h)", got.hb, want.hb, want.id));
      if (got.last !== want.last)
        report($sformatf("last flag got %b want %b (id %h)", got.last, want.last, want.id));
    endtask
  endclass

endpackage

// ===== tb/heartbeat_membership_table_unit_tb.sv =====
// ----------------------------------------------------------------------------
// heartbeat_membership_table_unit_tb: self-checking bench for the table
// directed joins, merges and ticks, then random phases under several register
// settings; every emitted event is checked against the predicted stream
// ----------------------------------------------------------------------------
module heartbeat_membership_table_unit_tb;
  import hmt_pkg::*;
  import hmt_tb_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int POOL = 12;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command_i = '0;
  logic [31:0] member_id_i = '0;
  logic [15:0] member_port_i = '0;
  logic [31:0] heartbeat_value_i = '0;
  logic [31:0] entry_time_i = '0;
  logic [31:0] current_time_i = '0;
  logic        out_valid_o;
  logic [2:0]  event_res_o;
  logic [31:0] out_id_o;
  logic [15:0] out_port_o;
  logic [31:0] out_heartbeat_o;
  logic        last_of_run_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  membership_scoreboard table_model;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;
  logic [31:0] now_t = '0;
  int          cur_timeout = 20;
  logic [31:0] id_pool [POOL];
  logic [15:0] port_pool [3];

  heartbeat_membership_table_unit #(.DEPTH(TABLE_DEPTH)) dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .member_id_i, .member_port_i,
    .heartbeat_value_i, .entry_time_i, .current_time_i, .out_valid_o,
    .event_res_o, .out_id_o, .out_port_o, .out_heartbeat_o, .last_of_run_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // event monitor: a result is taken at the edge that ends its cycle
  always @(posedge clk_i) begin
    table_event_t got;
    if (rst_ni && out_valid_o) begin
      got.ev   = ev_e'(event_res_o);
      got.id   = out_id_o;
      got.port = out_port_o;
      got.hb   = out_heartbeat_o;
      got.last = last_of_run_o;
      table_model.check_event(got);
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    table_model.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_cmd(cmd_e c, logic [31:0] id, logic [15:0] port,
                          logic [31:0] hb, logic [31:0] et, logic [31:0] now_v);
    int   gap;
    req_t r;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      @(posedge clk_i);
      // half the time the gap starts once the block has gone idle
      if ($urandom_range(0, 1)) while (busy) @(posedge clk_i);
      repeat (gap - 1) @(posedge clk_i);
    end
    command_i         <= c;
    member_id_i       <= id;
    member_port_i     <= port;
    heartbeat_value_i <= hb;
    entry_time_i      <= et;
    current_time_i    <= now_v;
    start             <= 1'b1;
    r.cmd  = c;
    r.id   = id;
    r.port = port;
    r.hb   = hb;
    r.et   = et;
    r.now  = now_v;
    do @(posedge clk_i); while (busy !== 1'b0);
    table_model.note_command(r);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (table_model.pending_count() != 0) @(posedge clk_i);
  endtask

  // a tick on an empty table emits nothing, so allow a full tick to finish
  task automatic drain_and_pause();
    hold_until_drained();
    repeat (4 * TABLE_DEPTH + 8) @(posedge clk_i);
  endtask

  task automatic random_item(bit fill);
    int          pick;
    cmd_e        c;
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic [31:0] et;
    logic [31:0] t;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) now_t = now_t + $urandom_range(0, 2 * cur_timeout + 2);
    else now_t = now_t + $urandom_range(0, 3);
    t = ($urandom_range(0, 32) == 0) ? $urandom() : now_t;
    if (pick < 18) c = CMD_TICK;
    else if (pick < (fill ? 60 : 40)) c = CMD_JOIN_REQ;
    else if (pick < (fill ? 80 : 58)) c = CMD_JOIN_REP;
    else c = CMD_MERGE;
    if (fill || $urandom_range(0, 6) == 0) begin
      id   = $urandom();
      port = 16'($urandom());
    end else begin
      id   = id_pool[$urandom_range(0, POOL - 1)];
      port = port_pool[$urandom_range(0, 2)];
    end
    case ($urandom_range(0, 9))
      0:       hb = $urandom();
      1:       hb = 32'hFFFF_FFFF;
      default: hb = $urandom_range(0, 40);
    endcase
    case ($urandom_range(0, 9))
      0, 1:    et = $urandom();
      2:       et = now_t + $urandom_range(1, 50);  // stamped ahead: age wraps large
      default: et = now_t - $urandom_range(0, cur_timeout);
    endcase
    send_cmd(c, id, port, hb, et, t);
  endtask

  task automatic run_phase(int items, int tmo, logic [31:0] oid, logic [31:0] oport,
                           logic [31:0] t0, bit fill);
    drain_and_pause();
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_OWN_ID, oid);
    write_reg(REG_OWN_PORT, oport);
    cur_timeout = tmo;
    now_t = t0;
    id_pool[0] = oid;
    port_pool[0] = oport[15:0];
    for (int i = 1; i < POOL; i++) id_pool[i] = $urandom();
    for (int i = 1; i < 3; i++) port_pool[i] = 16'($urandom());
    for (int i = 0; i < items; i++) begin
      if (i % 25 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == items / 2 || $urandom_range(0, 39) == 0) hold_until_drained();
      random_item(fill);
    end
  endtask

  initial begin
    table_model = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under the reset register values
    send_cmd(CMD_TICK,     32'd0,         16'd0,      32'd0,         32'd0,         32'd0);
    send_cmd(CMD_JOIN_REQ, 32'd1,         16'd0,      32'hFFFF_FFFF, 32'd0,         32'd5);
    send_cmd(CMD_JOIN_REP, 32'hFFFF_FFFF, 16'hFFFF,   32'd0,         32'hFFFF_FFFF, 32'd6);
    send_cmd(CMD_MERGE,    32'd0,         16'd0,      32'd5,         32'd3,         32'd7);
    send_cmd(CMD_JOIN_REQ, 32'd1,         16'd0,      32'd9,         32'd0,         32'd7);
    send_cmd(CMD_JOIN_REP, 32'd0,         16'd0,      32'd9,         32'd0,         32'd7);
    send_cmd(CMD_MERGE,    32'd0,         16'd0,      32'd5,         32'd7,         32'd8);
    send_cmd(CMD_MERGE,    32'd0,         16'd0,      32'd6,         32'd7,         32'd8);
    send_cmd(CMD_MERGE,    32'hFFFF_FFFF, 16'hFFFF,   32'hFFFF_FFFF, 32'd0,         32'd9);
    send_cmd(CMD_MERGE,    32'd1,         16'hFFFF,   32'd0,         32'hAAAA_AAAA, 32'd9);
    // own heartbeat wraps to zero here
    send_cmd(CMD_TICK,     32'd0,         16'd0,      32'd0,         32'd0,         32'd10);
    // ages of exactly the timeout are removed
    send_cmd(CMD_TICK,     32'd0,         16'd0,      32'd0,         32'd0,         32'd29);
    send_cmd(CMD_JOIN_REQ, 32'h5555_5555, 16'h5555,   32'hAAAA_AAAA, 32'd0,         32'd30);
    drain_and_pause();
    write_reg(REG_OWN_ID, 32'h0000_1234);
    write_reg(REG_OWN_PORT, 32'hFFFF_4321);
    // own entry absent from the table
    send_cmd(CMD_TICK,     32'd0,         16'd0,      32'd0,         32'd0,         32'd31);
    drain_and_pause();
    write_reg(REG_UNMAPPED, 32'd0);
    write_reg(REG_TIMEOUT, 32'd0);
    write_reg(REG_OWN_ID, 32'h5555_5555);
    write_reg(REG_OWN_PORT, 32'h0000_5555);
    // zero timeout clears everything, own entry included
    send_cmd(CMD_TICK,     32'd0,         16'd0,      32'd0,         32'd0,         32'd31);
    send_cmd(CMD_TICK,     32'hFFFF_FFFF, 16'hFFFF,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd32);

    run_phase(20,  0,     $urandom(),    $urandom(),    $urandom(),    1'b0);
    run_phase(70,  65535, 32'hFFFF_FFFF, 32'h0001_FFFF, $urandom(),    1'b1);
    run_phase(30,  1,     32'd0,         32'd0,         $urandom(),    1'b0);
    run_phase(130, $urandom_range(10, 60), $urandom(), $urandom(), $urandom(), 1'b0);
    run_phase(90,  30,    $urandom(),    $urandom(),    32'hFFFF_FF80, 1'b0);
    run_phase(120, $urandom_range(5, 200), $urandom(), $urandom(), $urandom(), 1'b0);

    drain_and_pause();
    if (table_model.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
